// ===== sv/pfa_pkg.sv =====
// Shared constants and types of the page table and free frame allocator.
package pfa_pkg;

  localparam int PAGES_PER_PROCESS = 2048;
  localparam int TOTAL_FRAMES      = 16384;
  localparam int RESERVED_FRAMES   = 4096;
  localparam int MAX_PROCESSES     = 16;

  // Port widths of the request and result fields.
  localparam int KIND_W  = 2;
  localparam int PROC_W  = 4;
  localparam int PAGE_W  = 11;
  localparam int FRAME_W = 14;
  localparam int FREE_W  = 14;

  localparam int TBL_DEPTH = MAX_PROCESSES * PAGES_PER_PROCESS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int PG_AW     = $clog2(PAGES_PER_PROCESS);
  localparam int RING_AW   = $clog2(TOTAL_FRAMES);
  localparam int CNT_W     = $clog2(TOTAL_FRAMES + 1);

  // Frames that sit in the ring right after reset, and the length of the
  // power-up fill pass that covers both the page table and the ring.
  localparam int INIT_FREE = (TOTAL_FRAMES > RESERVED_FRAMES) ?
                             (TOTAL_FRAMES - RESERVED_FRAMES) : 0;
  localparam int INIT_LEN  = (TBL_DEPTH > INIT_FREE) ? TBL_DEPTH : INIT_FREE;
  localparam int INIT_W    = $clog2(INIT_LEN);

  typedef enum logic [KIND_W-1:0] {
    KIND_TOUCH    = 2'd0,
    KIND_REL_PAGE = 2'd1,
    KIND_REL_PROC = 2'd2
  } kind_e;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  typedef struct packed {
    logic               pop;
    logic               push;
    logic               init_we;
    logic [FRAME_W-1:0] push_frame;
    logic [RING_AW-1:0] init_addr;
  } ring_ctl_t;

  typedef struct packed {
    logic [FRAME_W-1:0] head_frame;
    logic [CNT_W-1:0]   count_next;
    logic               empty;
  } ring_sts_t;

endpackage

// ===== sv/pfa_ring.sv =====
// Free frame ring: a circular FIFO of frame numbers with head and count.
module pfa_ring (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfa_pkg::ring_ctl_t ctl_i,
  output pfa_pkg::ring_sts_t sts_o
);
  import pfa_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  logic [FRAME_W-1:0] ring_mem [TOTAL_FRAMES];
  logic [FRAME_W-1:0] head_frame_q;
  logic [RING_AW-1:0] head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [SUM_W-1:0]   tail_sum, tail_wrap;
  logic [RING_AW-1:0] tail_addr;
  logic               full;
  logic               push_ok;
  logic [FRAME_W-1:0] init_frame;

  // The tail is head plus count, folded once since head stays below the depth and count never exceeds it.
  assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail_wrap = (tail_sum >= SUM_W'(TOTAL_FRAMES)) ?
                     (tail_sum - SUM_W'(TOTAL_FRAMES)) : tail_sum;
  assign tail_addr = tail_wrap[RING_AW-1:0];

  assign full       = (count_q == CNT_W'(TOTAL_FRAMES));
  assign push_ok    = ctl_i.push && !full;
  assign init_frame = FRAME_W'(RESERVED_FRAMES + int'(ctl_i.init_addr));

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (ctl_i.pop) begin
      head_d  = (head_q == RING_AW'(TOTAL_FRAMES - 1)) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end else if (push_ok) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= CNT_W'(INIT_FREE);
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.init_we) begin
      ring_mem[ctl_i.init_addr] <= init_frame;
    end else if (push_ok) begin
      ring_mem[tail_addr] <= ctl_i.push_frame;
    end
    head_frame_q <= ring_mem[head_q];
  end

  assign sts_o.head_frame = head_frame_q;
  assign sts_o.count_next = count_d;
  assign sts_o.empty      = (count_q == '0);

endmodule

// ===== sv/page_table_free_frame_allocator_unit.sv =====
// Page table per process with a FIFO free frame ring, driven by a small sequencer.
// A touch or a page release passes through a table read and an update before done_o,
// and no new request is taken until then; a rejected request answers from idle.
// A process release walks all 2048 pages, each with one table read and one update.
// After reset, busy_o stays high through a fill pass that clears the page table
// and loads the free frames into the ring. The receiver cannot stall the done_o strobe.
module page_table_free_frame_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [3:0]  process_i,
  input  logic [10:0] page_i,
  output logic        done_o,
  output logic        was_mapped_o,
  output logic        fault_o,
  output logic        no_frame_o,
  output logic [13:0] frame_o,
  output logic [13:0] free_count_o
);
  import pfa_pkg::*;

  // The sequencer is one-hot: fill pass, waiting, table read, update.
  typedef enum logic [3:0] {
    ST_INIT = 4'b0001,
    ST_IDLE = 4'b0010,
    ST_READ = 4'b0100,
    ST_EXEC = 4'b1000
  } state_e;

  typedef struct packed {
    logic               was_mapped;
    logic               fault;
    logic               no_frame;
    logic [FRAME_W-1:0] frame;
    logic [FREE_W-1:0]  free_count;
  } res_t;

  state_e             state_q, state_d;
  logic [INIT_W-1:0]  init_q, init_d;
  kind_e              kind_q, kind_d;
  logic [TBL_AW-1:0]  idx_q, idx_d;
  logic [PG_AW-1:0]   walk_q, walk_d;
  logic               any_q, any_d;
  logic               done_q, done_d;
  res_t               res_q, res_d;
  logic               res_we;

  // Page table memory: one write port, one registered read port.
  pte_t               tbl_mem [TBL_DEPTH];
  pte_t               tbl_rdata_q;
  pte_t               tbl_wdata;
  logic [TBL_AW-1:0]  tbl_waddr;
  logic               tbl_we;

  ring_ctl_t          ring_ctl;
  ring_sts_t          ring_sts;

  logic               req_ok;
  logic               walk_last;

  pfa_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ring_ctl),
    .sts_o  (ring_sts)
  );

  // A request is served only for a known kind, a process that exists and,
  // for single-page requests, a page inside the table.
  assign req_ok = (kind_i == KIND_TOUCH || kind_i == KIND_REL_PAGE ||
                   kind_i == KIND_REL_PROC) &&
                  (int'(process_i) < MAX_PROCESSES) &&
                  (kind_i == KIND_REL_PROC || int'(page_i) < PAGES_PER_PROCESS);

  assign walk_last = (walk_q == PG_AW'(PAGES_PER_PROCESS - 1));

  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    kind_d    = kind_q;
    idx_d     = idx_q;
    walk_d    = walk_q;
    any_d     = any_q;
    done_d    = 1'b0;
    res_we    = 1'b0;
    res_d     = '0;
    tbl_we    = 1'b0;
    tbl_waddr = idx_q;
    tbl_wdata = '0;
    ring_ctl  = '0;

    unique case (state_q)
      ST_INIT: begin
        // Clear one table entry and load one ring slot per cycle.
        tbl_we             = (int'(init_q) < TBL_DEPTH);
        tbl_waddr          = TBL_AW'(init_q);
        ring_ctl.init_we   = (int'(init_q) < INIT_FREE);
        ring_ctl.init_addr = RING_AW'(init_q);
        init_d             = init_q + 1'b1;
        if (init_q == INIT_W'(INIT_LEN - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          if (req_ok) begin
            kind_d  = kind_e'(kind_i);
            walk_d  = '0;
            any_d   = 1'b0;
            idx_d   = TBL_AW'(int'(process_i) * PAGES_PER_PROCESS +
                              ((kind_i == KIND_REL_PROC) ? 0 : int'(page_i)));
            state_d = ST_READ;
          end else begin
            // Rejected requests report only the current free count.
            done_d           = 1'b1;
            res_we           = 1'b1;
            res_d.free_count = FREE_W'(ring_sts.count_next);
          end
        end
      end

      ST_READ: begin
        // The table entry and the ring head are read at this edge.
        state_d = ST_EXEC;
      end

      ST_EXEC: begin
        unique case (kind_q)
          KIND_TOUCH: begin
            if (tbl_rdata_q.valid) begin
              res_d.was_mapped = 1'b1;
              res_d.frame      = tbl_rdata_q.frame;
            end else begin
              res_d.fault = 1'b1;
              if (ring_sts.empty) begin
                res_d.no_frame = 1'b1;
              end else begin
                ring_ctl.pop    = 1'b1;
                tbl_we          = 1'b1;
                tbl_wdata.valid = 1'b1;
                tbl_wdata.frame = ring_sts.head_frame;
                res_d.frame     = ring_sts.head_frame;
              end
            end
            done_d           = 1'b1;
            res_we           = 1'b1;
            res_d.free_count = FREE_W'(ring_sts.count_next);
            state_d          = ST_IDLE;
          end

          KIND_REL_PAGE, KIND_REL_PROC: begin
            // A mapped entry keeps its frame bits but loses its valid mark,
            // and the frame goes back to the ring's tail.
            if (tbl_rdata_q.valid) begin
              tbl_we              = 1'b1;
              tbl_wdata.valid     = 1'b0;
              tbl_wdata.frame     = tbl_rdata_q.frame;
              ring_ctl.push       = 1'b1;
              ring_ctl.push_frame = tbl_rdata_q.frame;
            end
            any_d = any_q | tbl_rdata_q.valid;
            if (kind_q == KIND_REL_PAGE) begin
              done_d           = 1'b1;
              res_we           = 1'b1;
              res_d.was_mapped = tbl_rdata_q.valid;
              res_d.frame      = tbl_rdata_q.valid ? tbl_rdata_q.frame : '0;
              res_d.free_count = FREE_W'(ring_sts.count_next);
              state_d          = ST_IDLE;
            end else if (walk_last) begin
              done_d           = 1'b1;
              res_we           = 1'b1;
              res_d.was_mapped = any_d;
              res_d.free_count = FREE_W'(ring_sts.count_next);
              state_d          = ST_IDLE;
            end else begin
              walk_d  = walk_q + 1'b1;
              idx_d   = idx_q + 1'b1;
              state_d = ST_READ;
            end
          end

          default: begin
            done_d           = 1'b1;
            res_we           = 1'b1;
            res_d.free_count = FREE_W'(ring_sts.count_next);
            state_d          = ST_IDLE;
          end
        endcase
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      init_q  <= '0;
      kind_q  <= KIND_TOUCH;
      walk_q  <= '0;
      any_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      kind_q  <= kind_d;
      walk_q  <= walk_d;
      any_q   <= any_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (res_we) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata_q <= tbl_mem[idx_q];
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign was_mapped_o = res_q.was_mapped;
  assign fault_o      = res_q.fault;
  assign no_frame_o   = res_q.no_frame;
  assign frame_o      = res_q.frame;
  assign free_count_o = res_q.free_count;

endmodule
